[src/piecewise_linear_color_map_macros.svh]
// Assertion helpers used by the checker
`ifndef PIECEWISE_LINEAR_COLOR_MAP_MACROS_SVH
`define PIECEWISE_LINEAR_COLOR_MAP_MACROS_SVH

// Implication checked outside of reset
`define PLCM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset
`define PLCM_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[src/plcm_pkg.sv]
package plcm_pkg;

  // One color table row as held in the table memory
  typedef struct packed {
    logic signed [31:0] bound;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [15:0]        alpha;
  } row_t;

  // Divider geometry: numerator up to 56 bits, quotient below 2**24
  localparam int NUM_W = 56;
  localparam int DEN_W = 32;
  localparam int QUO_W = 24;

  // Clamp status codes
  localparam logic [1:0] ST_INSIDE = 2'd0;
  localparam logic [1:0] ST_BELOW  = 2'd1;
  localparam logic [1:0] ST_ABOVE  = 2'd2;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MAP  = 1'b1;

endpackage

[src/plcm_div.sv]
// Restoring divider, one quotient bit per cycle.
// The caller guarantees numerator < divisor * 2**QUO_W.
module plcm_div import plcm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  localparam int CW = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] rem;
  logic [QUO_W-1:0] qsh;
  logic [CW-1:0]    cnt;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, qsh[QUO_W-1]};
  assign fits  = trial >= {1'b0, den};
  assign quo   = qsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= num[NUM_W-1:QUO_W];
        qsh <= num[QUO_W-1:0];
        cnt <= CW'(QUO_W);
      end else if (cnt != '0) begin
        rem  <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        qsh  <= {qsh[QUO_W-2:0], fits};
        cnt  <= cnt - 1'b1;
        done <= (cnt == CW'(1));
      end
    end
  end

endmodule

[src/piecewise_linear_color_map.sv]
// A load is written into the table memory when accepted. A map scans the table row by row
// (S_READ then S_CHECK, one memory read each) and, when interpolating, runs for each of the
// 4 channels a multiply (S_MUL_LO, S_MUL_HI, S_ADD) and then a serial divide.
// Commands are accepted only in S_IDLE, so a map finishes its scan and divides before the next.
// Reset (rst, synchronous): row_count returns to 2 and the sequencer idles;
// the table memory keeps its contents and is undefined until loaded.
module piecewise_linear_color_map import plcm_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [8:0]    cfg_wdata,      // row_count
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // row_index[7:0], row_red[15:8], row_green[23:16], row_blue[31:24],
  // row_alpha[47:32], row_bound[79:48], sample[111:80]
  input  logic [111:0]  s_axis_tdata,
  input  logic          s_axis_tuser,   // command
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // out_red[15:0], out_green[31:16], out_blue[47:32], out_alpha[63:48],
  // segment[71:64]
  output logic [71:0]   m_axis_tdata,
  output logic [1:0]    m_axis_tuser    // clamp_status
);

  localparam int AW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_CHECK, S_MUL_LO, S_MUL_HI, S_ADD, S_DIV_GO, S_DIV_WAIT, S_EMIT
  } state_t;

  state_t             state;
  logic [8:0]         row_count;
  row_t               mem [TABLE_DEPTH];
  row_t               rdata, lo_row, hi_row;
  logic [AW-1:0]      idx, last_idx;
  logic signed [31:0] smp;
  logic [31:0]        wlo, whi, span;
  logic [47:0]        prod, acc;
  logic [1:0]         ch;
  logic [15:0]        res [4];
  logic [7:0]         res_seg;
  logic [1:0]         res_st;
  logic               accept, div_done;
  logic [QUO_W-1:0]   div_quo;
  logic [NUM_W-1:0]   div_num;
  logic [AW:0]        n_minus1;
  logic signed [31:0] in_bound;

  assign in_bound      = s_axis_tdata[79:48];
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Effective last row index from row_count, with the row count clamped to [2, TABLE_DEPTH]
  always_comb begin
    if (row_count < 9'd2) n_minus1 = (AW+1)'(1);
    else if (32'(row_count) > TABLE_DEPTH) n_minus1 = (AW+1)'(TABLE_DEPTH - 1);
    else n_minus1 = (AW+1)'(row_count - 9'd1);
  end

  // Channel value of a row: red, green, blue, alpha
  function automatic logic [15:0] chan(row_t r, logic [1:0] c);
    logic [15:0] v;
    case (c)
      2'd0:    v = {8'h00, r.red};
      2'd1:    v = {8'h00, r.green};
      2'd2:    v = {8'h00, r.blue};
      default: v = r.alpha;
    endcase
    return v;
  endfunction

  // Config register
  always_ff @(posedge clk) begin
    if (rst) row_count <= 9'd2;
    else if (cfg_we) row_count <= cfg_wdata;
  end

  // Table memory: write on load, registered read at idx
  always_ff @(posedge clk) begin
    if (accept && s_axis_tuser == CMD_LOAD && 32'(s_axis_tdata[7:0]) < TABLE_DEPTH)
      mem[AW'(s_axis_tdata[7:0])] <= '{bound: in_bound, red: s_axis_tdata[15:8],
        green: s_axis_tdata[23:16], blue: s_axis_tdata[31:24],
        alpha: s_axis_tdata[47:32]};
    rdata <= mem[idx];
  end

  // Colors are scaled by 256, alpha is not
  assign div_num = (ch == 2'd3) ? NUM_W'(acc) : NUM_W'({acc, 8'h00});

  plcm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DIV_GO),
    .num   (div_num),
    .den   (span),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Sequencer: scan, then emit a clamped or stepped row, or run per-channel multiply and divide
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_EMIT) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && s_axis_tuser == CMD_MAP) begin
            smp      <= s_axis_tdata[111:80];
            idx      <= '0;
            last_idx <= AW'(n_minus1);
            state    <= S_READ;
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (idx == '0) begin
            lo_row <= rdata;
            if (smp < rdata.bound) begin
              res[0]  <= {rdata.red, 8'h00};
              res[1]  <= {rdata.green, 8'h00};
              res[2]  <= {rdata.blue, 8'h00};
              res[3]  <= rdata.alpha;
              res_seg <= '0;
              res_st  <= ST_BELOW;
              state   <= S_EMIT;
            end else begin
              idx   <= AW'(1);
              state <= S_READ;
            end
          end else if (lo_row.bound <= smp && smp <= rdata.bound) begin
            res_seg <= 8'(idx - 1'b1);
            res_st  <= ST_INSIDE;
            if (lo_row.bound == rdata.bound) begin
              // hard step: lower row unchanged
              res[0] <= {lo_row.red, 8'h00};
              res[1] <= {lo_row.green, 8'h00};
              res[2] <= {lo_row.blue, 8'h00};
              res[3] <= lo_row.alpha;
              state  <= S_EMIT;
            end else begin
              hi_row <= rdata;
              wlo    <= rdata.bound - smp;
              whi    <= smp - lo_row.bound;
              span   <= rdata.bound - lo_row.bound;
              ch     <= 2'd0;
              state  <= S_MUL_LO;
            end
          end else if (idx == last_idx) begin
            res[0]  <= {rdata.red, 8'h00};
            res[1]  <= {rdata.green, 8'h00};
            res[2]  <= {rdata.blue, 8'h00};
            res[3]  <= rdata.alpha;
            res_seg <= 8'(idx);
            res_st  <= ST_ABOVE;
            state   <= S_EMIT;
          end else begin
            lo_row <= rdata;
            idx    <= idx + 1'b1;
            state  <= S_READ;
          end
        end
        S_MUL_LO: begin
          prod  <= wlo * chan(lo_row, ch);
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          acc   <= prod;
          prod  <= whi * chan(hi_row, ch);
          state <= S_ADD;
        end
        S_ADD: begin
          acc   <= acc + prod;
          state <= S_DIV_GO;
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            res[ch] <= div_quo[15:0];
            ch      <= ch + 2'd1;
            state   <= (ch == 2'd3) ? S_EMIT : S_MUL_LO;
          end
        end
        S_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {res_seg, res[3], res[2], res[1], res[0]};
            m_axis_tuser  <= res_st;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/plcm_checker.sv]
`include "piecewise_linear_color_map_macros.svh"

// Port-level checks on the color map
module plcm_checker import plcm_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         cfg_we,
  input logic [8:0]   cfg_wdata,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [111:0] s_axis_tdata,
  input logic         s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [71:0]  m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  // A stalled result holds
  `PLCM_ASSERT_IMP(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, ##1 (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")
  // Status code 3 is never produced
  `PLCM_ASSERT_IMP(a_status_code, clk, rst, m_axis_tvalid, m_axis_tuser != 2'd3, "bad clamp status")
  // Below-range clamps always report segment 0
  `PLCM_ASSERT_IMP(a_below_seg, clk, rst, m_axis_tvalid && m_axis_tuser == ST_BELOW, m_axis_tdata[71:64] == 8'd0, "below clamp with nonzero segment")
  // After reset the block is ready and holds no result
  `PLCM_ASSERT_NEXT(a_reset_idle, clk, rst, s_axis_tready && !m_axis_tvalid, "not idle after reset")

endmodule

bind piecewise_linear_color_map plcm_checker u_plcm_checker (.*);

[tb/piecewise_linear_color_map_tb.sv]
module piecewise_linear_color_map_tb import plcm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 256;
  localparam int ITEM_GOAL  = 1950;
  localparam int STALL_MAX  = 20000;
  localparam int SETTLE     = 16;

  typedef struct {
    logic               cmd;
    logic [7:0]         idx;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [15:0]        alpha;
    logic signed [31:0] bound;
    logic signed [31:0] sample;
    bit                 drain_first;
  } color_cmd_t;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
    logic [7:0]  segment;
    logic [1:0]  status;
  } pixel_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [8:0]   cfg_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  piecewise_linear_color_map uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #4 clk = ~clk;

  // predictor state, updated as commands are accepted
  logic signed [31:0] tbl_bound [DEPTH];
  logic [7:0]         tbl_red   [DEPTH];
  logic [7:0]         tbl_green [DEPTH];
  logic [7:0]         tbl_blue  [DEPTH];
  logic [15:0]        tbl_alpha [DEPTH];
  logic [8:0]         rows_reg = 9'd2;

  // bounds as the stimulus will have left them, used to aim samples
  logic signed [31:0] plan_bound [DEPTH];

  color_cmd_t pending[$];
  pixel_t     pixels_due[$];
  color_cmd_t cur;
  int         queued = 0;
  int         taken = 0;
  int         errors = 0;
  int         stall_cycles = 0;
  int         send_idle = 31;
  int         recv_idle = 81;

  function automatic logic [15:0] blend(longint unsigned wlo, longint unsigned vlo,
                                        longint unsigned whi, longint unsigned vhi,
                                        longint unsigned scale, longint unsigned den);
    longint unsigned q;
    q = ((wlo * vlo + whi * vhi) * scale) / den;
    return q[15:0];
  endfunction

  function automatic pixel_t row_pixel(int r, int seg, logic [1:0] st);
    pixel_t p;
    p.red     = {tbl_red[r], 8'h00};
    p.green   = {tbl_green[r], 8'h00};
    p.blue    = {tbl_blue[r], 8'h00};
    p.alpha   = tbl_alpha[r];
    p.segment = seg[7:0];
    p.status  = st;
    return p;
  endfunction

  // expected color for one map command
  function automatic pixel_t map_color(logic signed [31:0] s);
    int n;
    int i;
    longint b0;
    longint b1;
    longint unsigned den;
    longint unsigned wlo;
    longint unsigned whi;
    pixel_t p;
    n = rows_reg;
    if (n < 2) n = 2;
    if (n > DEPTH) n = DEPTH;
    if (s < tbl_bound[0]) return row_pixel(0, 0, ST_BELOW);
    for (i = 0; i + 1 < n; i++)
      if (tbl_bound[i] <= s && s <= tbl_bound[i+1]) break;
    if (i + 1 >= n) return row_pixel(n - 1, n - 1, ST_ABOVE);
    b0 = tbl_bound[i];
    b1 = tbl_bound[i+1];
    if (b0 == b1) return row_pixel(i, i, ST_INSIDE);
    den = b1 - b0;
    wlo = b1 - longint'(s);
    whi = longint'(s) - b0;
    p.red     = blend(wlo, tbl_red[i],   whi, tbl_red[i+1],   256, den);
    p.green   = blend(wlo, tbl_green[i], whi, tbl_green[i+1], 256, den);
    p.blue    = blend(wlo, tbl_blue[i],  whi, tbl_blue[i+1],  256, den);
    p.alpha   = blend(wlo, tbl_alpha[i], whi, tbl_alpha[i+1], 1, den);
    p.segment = i[7:0];
    p.status  = ST_INSIDE;
    return p;
  endfunction

  // driver: one transaction presented at a time
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        taken++;
        if (cur.cmd == CMD_LOAD) begin
          tbl_bound[cur.idx] = cur.bound;
          tbl_red[cur.idx]   = cur.red;
          tbl_green[cur.idx] = cur.green;
          tbl_blue[cur.idx]  = cur.blue;
          tbl_alpha[cur.idx] = cur.alpha;
        end else begin
          pixels_due.push_back(map_color(cur.sample));
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending.size() > 0 && !(pending[0].drain_first && pixels_due.size() > 0)
            && $urandom_range(99) >= send_idle) begin
          cur = pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur.cmd;
          s_axis_tdata  <= {cur.sample, cur.bound, cur.alpha, cur.blue, cur.green,
                            cur.red, cur.idx};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // idle pattern follows progress through the stimulus
  always @(posedge clk) begin
    if (taken < ITEM_GOAL / 3) begin
      send_idle <= 31; recv_idle <= 81;
    end else if (taken < 2 * ITEM_GOAL / 3) begin
      send_idle <= 81; recv_idle <= 31;
    end else begin
      send_idle <= 0; recv_idle <= 0;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixels_due.size() == 0) begin
          $error("unexpected result transaction: tdata %h", m_axis_tdata);
          errors++;
        end else begin
          want = pixels_due.pop_front();
          if (m_axis_tdata[15:0] !== want.red) begin
            $error("out_red exp %0d got %0d", want.red, m_axis_tdata[15:0]); errors++;
          end
          if (m_axis_tdata[31:16] !== want.green) begin
            $error("out_green exp %0d got %0d", want.green, m_axis_tdata[31:16]); errors++;
          end
          if (m_axis_tdata[47:32] !== want.blue) begin
            $error("out_blue exp %0d got %0d", want.blue, m_axis_tdata[47:32]); errors++;
          end
          if (m_axis_tdata[63:48] !== want.alpha) begin
            $error("out_alpha exp %0d got %0d", want.alpha, m_axis_tdata[63:48]); errors++;
          end
          if (m_axis_tdata[71:64] !== want.segment) begin
            $error("segment exp %0d got %0d", want.segment, m_axis_tdata[71:64]); errors++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("clamp_status exp %0d got %0d", want.status, m_axis_tuser); errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog: cycles with no transaction on either side and no config write
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_load(int idx, int r, int g, int b, int a, logic signed [31:0] bnd);
    color_cmd_t c;
    c = '{CMD_LOAD, idx[7:0], r[7:0], g[7:0], b[7:0], a[15:0], bnd, $urandom, 1'b0};
    plan_bound[idx] = bnd;
    pending.push_back(c);
    queued++;
  endtask

  task automatic push_map(logic signed [31:0] s, bit hold = 1'b0);
    color_cmd_t c;
    c = '{CMD_MAP, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
          16'($urandom), $urandom, s, hold};
    pending.push_back(c);
    queued++;
  endtask

  function automatic int rand_alpha();
    if ($urandom_range(15) == 0) return $urandom_range(65535);
    return $urandom_range(32768);
  endfunction

  // style 0 monotonic, 1 monotonic with repeated bounds, 2 scrambled
  task automatic load_table(int n, int style);
    longint b;
    int step;
    b = longint'($signed($urandom)) >>> 2;
    for (int i = 0; i < n; i++) begin
      if (style == 2) b = longint'($signed($urandom));
      push_load(i, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                rand_alpha(), b[31:0]);
      step = (style == 1 && $urandom_range(2) == 0) ? 0 : $urandom_range(1 << 22);
      if (style != 2) b += step;
    end
  endtask

  function automatic logic signed [31:0] aim_sample(int n);
    longint lo;
    longint hi;
    int k;
    k = $urandom_range(n - 2);
    lo = plan_bound[k];
    hi = plan_bound[k+1];
    case ($urandom_range(9))
      0: lo = plan_bound[$urandom_range(n - 1)];
      1: lo = longint'(plan_bound[0]) - $urandom_range(1, 3);
      2: lo = longint'(plan_bound[n-1]) + $urandom_range(1, 3);
      3: lo = longint'($signed($urandom));
      4: lo = $urandom_range(1) ? 64'sd2147483647 : -64'sd2147483648;
      default: if (hi > lo) lo = lo + ({$urandom, $urandom} % (hi - lo + 1));
    endcase
    if (lo > 64'sd2147483647) lo = 64'sd2147483647;
    if (lo < -64'sd2147483648) lo = -64'sd2147483648;
    return lo[31:0];
  endfunction

  task automatic write_rows(int v);
    wait (taken == queued && pixels_due.size() == 0);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[8:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    rows_reg  = v[8:0];
  endtask

  initial begin
    int cfgv;
    int n;
    int maps;
    bit held;
    held = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // fill the whole table so no later map reads an empty row
    for (int i = 0; i < DEPTH; i++)
      push_load(i, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                rand_alpha(), (i == DEPTH - 1) ? 32'sh7fffffff
                : 32'sh80000000 + i * (1 << 24) + $urandom_range(1000));
    write_rows(2);

    // directed: field extremes, equal bounds, clamps
    push_load(0, 0, 255, 0, 32768, 32'sh80000000);
    push_load(1, 255, 0, 255, 0, 32'sh7fffffff);
    push_map(32'sh80000000);
    push_map(32'sh7fffffff);
    push_map(32'sh00000000);
    push_load(0, 10, 20, 30, 65535, 0);
    push_load(1, 40, 50, 60, 100, 0);
    push_map(0);
    push_map(-1);
    push_map(1);
    push_load(1, 200, 100, 50, 32768, 100 << 16);
    push_map(50 << 16);
    push_map(100 << 16);
    push_map(32'sh7fffffff);
    push_load(255, 255, 255, 255, 32768, 32'sh7fffffff);
    write_rows(0);
    push_map(32'sh00000001);
    write_rows(511);
    push_map(32'sh80000000);
    push_map(32'sh7ffffffe);
    push_map(32'sh10000000);
    write_rows(1);
    push_map(3 << 16);

    // random phases, each with its own row count and table
    while (queued < ITEM_GOAL) begin
      case ($urandom_range(19))
        0: cfgv = ($urandom_range(1)) ? 256 : $urandom_range(257, 511);
        1: cfgv = $urandom_range(1);
        2, 3: cfgv = $urandom_range(13, 40);
        default: cfgv = $urandom_range(2, 12);
      endcase
      write_rows(cfgv);
      n = (cfgv < 2) ? 2 : (cfgv > DEPTH) ? DEPTH : cfgv;
      load_table(n, ($urandom_range(5) == 0) ? 2 : ($urandom_range(3) == 0) ? 1 : 0);
      maps = (n > 40) ? 4 : $urandom_range(15, 40);
      for (int m = 0; m < maps; m++) begin
        if ($urandom_range(7) == 0)
          push_load($urandom_range(255), $urandom_range(255), $urandom_range(255),
                    $urandom_range(255), rand_alpha(), $urandom);
        push_map(aim_sample(n), !held && m == maps / 2);
        if (m == maps / 2) held = 1'b1;
      end
    end

    wait (taken == queued && pixels_due.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/plcm_pkg.sv
src/plcm_div.sv
src/piecewise_linear_color_map.sv
src/plcm_checker.sv
tb/piecewise_linear_color_map_tb.sv
